// ----- design/point_in_polygon_classifier_defines.svh -----
// Assertion macros of the point-in-polygon classifier RTL.
`ifndef POINT_IN_POLYGON_CLASSIFIER_DEFINES_SVH
`define POINT_IN_POLYGON_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PIP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pip_pkg.sv -----
// Types, constants and helper functions of the point-in-polygon classifier.
`default_nettype none

package pip_pkg;

  // Field widths
  localparam int COORD_W = 15;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 8;
  localparam int LOC_W   = 2;

  // Internal arithmetic widths
  localparam int DIFF_W = 16;
  localparam int MUL_W  = 32;
  localparam int SUM_W  = 34;

  // Request function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Location codes
  localparam logic [LOC_W-1:0] LOC_OUTSIDE = 2'd0;
  localparam logic [LOC_W-1:0] LOC_EDGE    = 2'd1;
  localparam logic [LOC_W-1:0] LOC_INSIDE  = 2'd2;

  // x step of the test ray; its y step is one
  localparam logic signed [DIFF_W-1:0] RAY_DX = 16'sd20129;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pip_vtx_t;

  // Vertex write broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    pip_vtx_t           vtx;
  } pip_wr_t;

  // Query moving down the chain with its running flags
  typedef struct packed {
    logic                      vld;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      on;
    logic                      odd;
  } pip_pkt_t;

  // Difference of two coordinates, sign extended
  function automatic logic signed [DIFF_W-1:0] coord_sub(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // Product of a and b is strictly positive
  function automatic logic same_sign_nz(
    input logic signed [DIFF_W-1:0] a,
    input logic signed [DIFF_W-1:0] b
  );
    logic a_pos, a_neg, b_pos, b_neg;
    a_neg = a[DIFF_W-1];
    b_neg = b[DIFF_W-1];
    a_pos = !a_neg && (|a);
    b_pos = !b_neg && (|b);
    return (a_pos && b_pos) || (a_neg && b_neg);
  endfunction

  // a and b lie strictly on opposite sides of zero
  function automatic logic sign_opposite(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic a_pos, a_neg, b_pos, b_neg;
    a_neg = a[SUM_W-1];
    b_neg = b[SUM_W-1];
    a_pos = !a_neg && (|a);
    b_pos = !b_neg && (|b);
    return (a_pos && b_neg) || (a_neg && b_pos);
  endfunction

endpackage

`default_nettype wire

// ----- design/pip_cell.sv -----
// One chain cell: holds one vertex and tests a passing query against its edge.
`default_nettype none

module pip_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pip_pkg::pip_wr_t  wr_i,
  input  logic [CNT_W-1:0]  count_i,
  input  pip_pkg::pip_vtx_t next_i,
  input  pip_pkg::pip_vtx_t first_i,
  output pip_pkg::pip_vtx_t vtx_o,
  input  pip_pkg::pip_pkt_t pkt_i,
  output pip_pkg::pip_pkt_t pkt_o
);
  import pip_pkg::*;

  pip_vtx_t vtx_r, vtx_nxt;

  logic active;
  logic last;
  pip_vtx_t far_vtx;

  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb, ex, ey;

  // Stage 1 registers
  pip_pkt_t                 s1_pkt_r, s1_pkt_nxt;
  logic                     s1_box_out_r, s1_box_out_nxt;
  logic signed [DIFF_W-1:0] s1_dxa_r, s1_dxa_nxt;
  logic signed [DIFF_W-1:0] s1_dxb_r, s1_dxb_nxt;
  logic signed [DIFF_W-1:0] s1_ex_r, s1_ex_nxt;
  logic signed [MUL_W-1:0]  s1_m_eydxa_r, s1_m_eydxa_nxt;
  logic signed [MUL_W-1:0]  s1_m_exdya_r, s1_m_exdya_nxt;
  logic signed [MUL_W-1:0]  s1_m_kdya_r, s1_m_kdya_nxt;
  logic signed [MUL_W-1:0]  s1_m_kdyb_r, s1_m_kdyb_nxt;
  logic signed [MUL_W-1:0]  s1_m_key_r, s1_m_key_nxt;

  // Stage 2
  logic signed [SUM_W-1:0] c1, c2, c3, c4;
  logic on_hit, cross_hit, hit_en;
  pip_pkt_t out_pkt_r, out_pkt_nxt;

  // Edge runs from this vertex to the next one, or back to vertex 0 in the last active cell
  assign active  = 32'(count_i) > 32'(CELL_IDX);
  assign last    = 32'(count_i) == 32'(CELL_IDX + 1);
  assign far_vtx = last ? first_i : next_i;
  assign vtx_o   = vtx_r;

  // Vertex slot write
  always_comb begin
    vtx_nxt = vtx_r;
    if (wr_i.en && (32'(wr_i.index) == 32'(CELL_IDX))) begin
      vtx_nxt = wr_i.vtx;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt;
  end

  // Stage 1: differences and products
  always_comb begin
    dxa = coord_sub(vtx_r.x, pkt_i.px);
    dya = coord_sub(vtx_r.y, pkt_i.py);
    dxb = coord_sub(far_vtx.x, pkt_i.px);
    dyb = coord_sub(far_vtx.y, pkt_i.py);
    ex  = coord_sub(far_vtx.x, vtx_r.x);
    ey  = coord_sub(far_vtx.y, vtx_r.y);

    s1_pkt_nxt     = pkt_i;
    s1_box_out_nxt = same_sign_nz(dxa, dxb) || same_sign_nz(dya, dyb);
    s1_dxa_nxt     = dxa;
    s1_dxb_nxt     = dxb;
    s1_ex_nxt      = ex;
    s1_m_eydxa_nxt = MUL_W'(ey) * MUL_W'(dxa);
    s1_m_exdya_nxt = MUL_W'(ex) * MUL_W'(dya);
    s1_m_kdya_nxt  = MUL_W'(RAY_DX) * MUL_W'(dya);
    s1_m_kdyb_nxt  = MUL_W'(RAY_DX) * MUL_W'(dyb);
    s1_m_key_nxt   = MUL_W'(RAY_DX) * MUL_W'(ey);
  end

  // Stage 2: cross products against the ray and the edge line
  always_comb begin
    c1 = SUM_W'(s1_m_kdya_r) - SUM_W'(s1_dxa_r);
    c2 = SUM_W'(s1_m_kdyb_r) - SUM_W'(s1_dxb_r);
    c3 = SUM_W'(s1_m_eydxa_r) - SUM_W'(s1_m_exdya_r);
    c4 = c3 + SUM_W'(s1_ex_r) - SUM_W'(s1_m_key_r);

    on_hit    = !s1_box_out_r && (c3 == '0);
    cross_hit = sign_opposite(c1, c2) && sign_opposite(c3, c4);
    hit_en    = s1_pkt_r.vld && active;

    out_pkt_nxt     = s1_pkt_r;
    out_pkt_nxt.on  = s1_pkt_r.on | (hit_en & on_hit);
    out_pkt_nxt.odd = s1_pkt_r.odd ^ (hit_en & cross_hit);
  end

  // Packet registers, moved only when the chain advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pkt_r  <= '0;
      out_pkt_r <= '0;
    end else if (adv) begin
      s1_pkt_r  <= s1_pkt_nxt;
      out_pkt_r <= out_pkt_nxt;
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_box_out_r <= s1_box_out_nxt;
      s1_dxa_r     <= s1_dxa_nxt;
      s1_dxb_r     <= s1_dxb_nxt;
      s1_ex_r      <= s1_ex_nxt;
      s1_m_eydxa_r <= s1_m_eydxa_nxt;
      s1_m_exdya_r <= s1_m_exdya_nxt;
      s1_m_kdya_r  <= s1_m_kdya_nxt;
      s1_m_kdyb_r  <= s1_m_kdyb_nxt;
      s1_m_key_r   <= s1_m_key_nxt;
    end
  end

  assign pkt_o = out_pkt_r;

endmodule

`default_nettype wire

// ----- design/point_in_polygon_classifier.sv -----
// Top level of the point-in-polygon classifier: cell chain, request control, result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | request   | in_valid/in_ready  | in_func, in_vertex_index, in_point_x/_y
//   out     | result    | out_valid/out_ready| out_location
//   cfg     | write     | cfg_wr_en          | cfg_wr_data (vertex_count)
//
// A query walks the chain of MAX_VERTICES cells, two register stages per cell, and then the
// result register; queries stream one per cycle while the result is not stalled.
// A load writes its cell directly and is taken only once every earlier query has left.
// Reset is synchronous, clears the chain's valid bits and the counters and sets vertex_count
// to 3; vertex storage has no reset. A stalled result freezes the whole chain.
`default_nettype none
`include "point_in_polygon_classifier_defines.svh"

module point_in_polygon_classifier #(
  parameter int MAX_VERTICES = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pip_pkg::COUNT_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [pip_pkg::INDEX_W-1:0]         in_vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [pip_pkg::COORD_W-1:0]  in_point_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pip_pkg::LOC_W-1:0]           out_location
);
  import pip_pkg::*;

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int QW = $clog2(2 * MAX_VERTICES + 2);

  logic [COUNT_W-1:0] vertex_count_r, vertex_count_nxt;
  logic [NW-1:0]      count_eff;

  logic adv;
  logic chain_idle;
  logic acc_in, acc_query, acc_load, acc_out;

  logic [QW-1:0]    inflight_r, inflight_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LOC_W-1:0] out_location_r, out_location_nxt;

  pip_wr_t  wr;
  pip_pkt_t pkt [MAX_VERTICES+1];
  pip_vtx_t vtx [MAX_VERTICES];

  // Vertex count register; the count given to the cells is clamped to the chain length
  always_comb begin
    vertex_count_nxt = vertex_count_r;
    if (cfg_wr_en) begin
      vertex_count_nxt = cfg_wr_data;
    end
    if (32'(vertex_count_r) > 32'(MAX_VERTICES)) begin
      count_eff = NW'(MAX_VERTICES);
    end else begin
      count_eff = NW'(vertex_count_r);
    end
  end

  // Request handshake; loads wait for an empty chain
  assign adv        = !out_valid_r || out_ready;
  assign chain_idle = (inflight_r == '0);
  assign in_ready   = adv && ((in_func == FUNC_QUERY) || chain_idle);
  assign acc_in     = in_valid && in_ready;
  assign acc_query  = acc_in && (in_func == FUNC_QUERY);
  assign acc_load   = acc_in && (in_func == FUNC_LOAD);
  assign acc_out    = out_valid_r && out_ready;

  // Vertex write broadcast
  always_comb begin
    wr.en    = acc_load;
    wr.index = in_vertex_index;
    wr.vtx.x = in_point_x;
    wr.vtx.y = in_point_y;
  end

  // Query injection at the head of the chain: valid, point, clear on and odd flags
  assign pkt[0] = {acc_query, in_point_x, in_point_y, 1'b0, 1'b0};

  // Cell chain
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pip_cell #(
      .CELL_IDX (i),
      .CNT_W    (NW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_i    (wr),
      .count_i (count_eff),
      .next_i  (vtx[(i + 1) % MAX_VERTICES]),
      .first_i (vtx[0]),
      .vtx_o   (vtx[i]),
      .pkt_i   (pkt[i]),
      .pkt_o   (pkt[i+1])
    );
  end

  // Queries in flight, chain plus result register
  assign inflight_nxt = inflight_r + QW'(acc_query) - QW'(acc_out);

  // Result register
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_location_nxt = out_location_r;
    if (adv) begin
      out_valid_nxt = pkt[MAX_VERTICES].vld;
      priority if (pkt[MAX_VERTICES].on) begin
        out_location_nxt = LOC_EDGE;
      end else if (pkt[MAX_VERTICES].odd) begin
        out_location_nxt = LOC_INSIDE;
      end else begin
        out_location_nxt = LOC_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= COUNT_W'(3);
      inflight_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      inflight_r     <= inflight_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_location_r <= out_location_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_location = out_location_r;

  // Checks
  `PIP_ASSERT_NOW(a_load_on_empty, clk, rst_n, acc_load, chain_idle,
    "load taken while queries are in flight")
  `PIP_ASSERT_NOW(a_result_counted, clk, rst_n, out_valid_r, !chain_idle,
    "result shown with no query in flight")
  `PIP_ASSERT_NEXT(a_count_bound, clk, rst_n, 1'b1,
    32'(inflight_r) <= 32'(2 * MAX_VERTICES + 1), "in-flight count beyond chain depth")

endmodule

`default_nettype wire
